// ----- hw/rtl/arpc_pkg.sv -----
`default_nettype none

package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 128;
  localparam int unsigned SLOT_W      = 7;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd15;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [47:0]       mac_out;
    logic              stored;
    logic [SLOT_W-1:0] slot_index;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/arpc_mem.sv -----
`default_nettype none

module arpc_mem #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire arpc_pkg::entry_t wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output arpc_pkg::entry_t      rdata_o
);

  arpc_pkg::entry_t mem [ENTRIES];
  arpc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/arpc_scan.sv -----
`default_nettype none

module arpc_scan #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire arpc_pkg::in_t                      in_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output arpc_pkg::out_t                          out_o,
  input  wire logic [31:0]                        seconds_i,
  input  wire logic [arpc_pkg::TIMEOUT_W-1:0]     timeout_i,
  output logic                                    mem_we_o,
  output logic [AW-1:0]                           mem_waddr_o,
  output arpc_pkg::entry_t                        mem_wdata_o,
  output logic                                    mem_re_o,
  output logic [AW-1:0]                           mem_raddr_o,
  input  wire arpc_pkg::entry_t                   mem_rdata_i
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  arpc_pkg::state_e state_q, state_d;
  arpc_pkg::op_e    op_q, op_d;
  logic [31:0]      ip_q, ip_d;
  logic [47:0]      mac_q, mac_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  arpc_pkg::out_t   res_q, res_d;
  arpc_pkg::out_t   out_q;
  logic             out_valid_q, out_valid_d;
  logic             load_out;
  logic             last;
  logic             expired;
  logic [31:0]      age;

  assign age     = seconds_i - mem_rdata_i.stamp;
  assign expired = age > {16'b0, timeout_i};
  assign last    = pidx_q == AW'(ENTRIES - 1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ip_d        = ip_q;
    mac_d       = mac_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    res_d       = res_q;
    load_out    = 1'b0;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pidx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[AW-1:0];
    unique case (state_q)
      arpc_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[AW-1:0];
        mem_wdata_o = '0;
        cnt_d       = cnt_q + CW'(1);
        if (cnt_q == CW'(ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = arpc_pkg::ST_IDLE;
        end
      end
      arpc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_i.op;
          ip_d  = in_i.ip_addr;
          mac_d = in_i.mac_addr;
          res_d = '0;
          cnt_d = '0;
          unique case (in_i.op)
            arpc_pkg::OP_LOOKUP,
            arpc_pkg::OP_INSERT,
            arpc_pkg::OP_TICK: state_d = arpc_pkg::ST_SCAN;
            default:           state_d = arpc_pkg::ST_DONE;
          endcase
        end
      end
      arpc_pkg::ST_SCAN: begin
        if (cnt_q != CW'(ENTRIES)) begin
          mem_re_o = 1'b1;
          cnt_d    = cnt_q + CW'(1);
          pv_d     = 1'b1;
          pidx_d   = cnt_q[AW-1:0];
        end
        if (pv_q) begin
          unique case (op_q)
            arpc_pkg::OP_LOOKUP: begin
              if (mem_rdata_i.valid && (mem_rdata_i.ip == ip_q)) begin
                res_d.found      = 1'b1;
                res_d.mac_out    = mem_rdata_i.mac;
                res_d.slot_index = arpc_pkg::SLOT_W'(pidx_q);
              end
              if (last) begin
                state_d = arpc_pkg::ST_DONE;
              end
            end
            arpc_pkg::OP_INSERT: begin
              if (!mem_rdata_i.valid) begin
                mem_we_o          = 1'b1;
                mem_wdata_o.valid = 1'b1;
                mem_wdata_o.ip    = ip_q;
                mem_wdata_o.mac   = mac_q;
                mem_wdata_o.stamp = seconds_i;
                res_d.stored      = 1'b1;
                res_d.slot_index  = arpc_pkg::SLOT_W'(pidx_q);
                state_d           = arpc_pkg::ST_DONE;
              end else if (last) begin
                state_d = arpc_pkg::ST_DONE;
              end
            end
            arpc_pkg::OP_TICK: begin
              if (mem_rdata_i.valid && expired) begin
                mem_we_o          = 1'b1;
                mem_wdata_o.valid = 1'b0;
              end
              if (last) begin
                state_d = arpc_pkg::ST_DONE;
              end
            end
            default: state_d = arpc_pkg::ST_DONE;
          endcase
        end
      end
      arpc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = arpc_pkg::ST_IDLE;
        end
      end
      default: state_d = arpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpc_pkg::ST_CLEAR;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ip_q   <= ip_d;
    mac_q  <= mac_d;
    pidx_q <= pidx_d;
    res_q  <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/arp_cache_with_aging.sv -----
// ARP cache with aging. The table of ENTRIES IP-to-MAC mappings lives in one
// single-port-read, single-port-write memory and every lookup, insert or tick
// walks it one entry per cycle through the one read port: a lookup or a tick
// scans all entries, an insert stops at the first free slot, and an unused op
// skips the scan. After reset a clearing pass marks every entry invalid; no
// input transaction is taken during it, while writes to the timeout register
// (cfg_wdata_i) are taken at any time. The result register lets the next
// input transaction start while the previous result waits on the output.
`default_nettype none

module arp_cache_with_aging #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire arpc_pkg::in_t                  in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output arpc_pkg::out_t                      out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [arpc_pkg::TIMEOUT_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0]                    seconds_q, seconds_d;
  logic [arpc_pkg::TIMEOUT_W-1:0] timeout_q, timeout_d;
  logic                           tick_acc;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  arpc_pkg::entry_t               mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  arpc_pkg::entry_t               mem_rdata;

  assign tick_acc  = in_valid_i && in_ready_o && (in_i.op == arpc_pkg::OP_TICK);
  assign seconds_d = tick_acc ? seconds_q + 32'd1 : seconds_q;
  assign timeout_d = cfg_we_i ? cfg_wdata_i : timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_q <= '0;
      timeout_q <= arpc_pkg::TIMEOUT_RST;
    end else begin
      seconds_q <= seconds_d;
      timeout_q <= timeout_d;
    end
  end

  arpc_mem #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  arpc_scan #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .seconds_i   (seconds_q),
    .timeout_i   (timeout_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_we)
    else $error("memory written while idle");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> seconds_q == $past(seconds_q) + 32'd1)
    else $error("tick did not advance seconds counter");

  a_found_xor_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.found && out_o.stored))
    else $error("result flags both set");

  a_miss_zero_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.found) |-> (out_o.mac_out == '0))
    else $error("mac nonzero without hit");

endmodule

`default_nettype wire
